### hw/rtl/joint_position_velocity_filter_assert.svh
// ----------------------------------------------------------------------------
// joint position/velocity filter assertion macros
// concurrent checks on clk, disabled while arst_n is low; empty for synthesis
// ----------------------------------------------------------------------------
`ifndef JOINT_POSITION_VELOCITY_FILTER_ASSERT_SVH
`define JOINT_POSITION_VELOCITY_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define JPVF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define JPVF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define JPVF_ASSERT_IMP(lbl, ante, cons, msg)
`define JPVF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/jpvf_pkg.sv
// ----------------------------------------------------------------------------
// jpvf_pkg
// shared types and constants of the joint position/velocity filter
// ----------------------------------------------------------------------------
`default_nettype none

package jpvf_pkg;

	localparam int unsigned JOINTS_DEF = 16;
	localparam int unsigned JOINT_W    = 4;
	localparam int unsigned GAIN_W     = 15;
	localparam int unsigned PERIOD_W   = 30;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [GAIN_W-1:0]   POLE_RST = 15'd19661;
	localparam logic [GAIN_W-1:0]   TAP_RST  = 15'd6488;
	localparam logic [PERIOD_W-1:0] NS_PER_S = 30'd1000000000;

	localparam logic [CFG_IDX_W-1:0] CFG_POLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP  = 1'd1;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic [JOINT_W-1:0]  joint_index;
		logic signed [31:0]  position_sample;
		logic [PERIOD_W-1:0] period_ns;
	} sample_t;

	typedef struct packed {
		logic [JOINT_W-1:0] joint_out;
		logic signed [31:0] filtered_position_out;
		logic signed [31:0] filtered_velocity_out;
		logic               velocity_saturated;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/jpvf_if.sv
// ----------------------------------------------------------------------------
// jpvf stream interfaces
// valid/ready channels carrying sample and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface jpvf_sample_if;
	logic              valid;
	logic              ready;
	jpvf_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jpvf_result_if;
	logic              valid;
	logic              ready;
	jpvf_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/joint_position_velocity_filter.sv
// ----------------------------------------------------------------------------
// joint_position_velocity_filter
// per-joint iir low-pass of position and velocity with finite-difference rate
//
// sample channel: joint index, raw Q16.16 position and elapsed period in ns.
// result channel: joint, filtered position, filtered velocity, saturation flag.
// config port: cfg_we/cfg_index/cfg_wdata writes pole (0) or tap (1) gain.
// a word with zero period or a joint index of JOINTS or more is taken and
// dropped; the block is ready again on the next cycle and no result appears.
// any other word keeps ready low from accept until its result is loaded into
// the output register, so no new word is taken before the block is through
// with the last one: two one-bit-per-cycle divisions dominate, plus
// multiply-accumulate passes through the single 30x32 multiplier.
// the result sits in an output register; a new word is taken while it waits,
// and the block holds its finished word until the register is free.
// reset restores the default gains and clears the joint state (valid bits
// make every joint read as zero until first written).
// ----------------------------------------------------------------------------
`default_nettype none
`include "joint_position_velocity_filter_assert.svh"

module joint_position_velocity_filter #(
	parameter int unsigned JOINTS = jpvf_pkg::JOINTS_DEF
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 cfg_we,
	input wire [jpvf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input wire [jpvf_pkg::GAIN_W-1:0]          cfg_wdata,
	jpvf_sample_if.sink                        sample,
	jpvf_result_if.source                      result
);

	localparam int unsigned IDX_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int unsigned JW_W   = IDX_W + jpvf_pkg::JOINT_W;
	localparam int unsigned STEP_W = 6;

	localparam logic [STEP_W-1:0] STEP_ZERO = 6'd0;
	localparam logic [STEP_W-1:0] LP_LAST   = 6'd4;
	localparam logic [STEP_W-1:0] RT_LAST   = 6'd2;
	localparam logic [STEP_W-1:0] DIV_LAST  = 6'd34;

	localparam logic signed [63:0] RND_HALF = 64'sd16384;
	localparam logic [32:0] RT_POS_LIM = 33'h0_7fff_ffff;
	localparam logic [32:0] RT_NEG_LIM = 33'h0_8000_0000;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_MAC  = 6'b000100,
		ST_PREP = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		PH_POS  = 4'b0001,
		PH_TMPV = 4'b0010,
		PH_VEL  = 4'b0100,
		PH_RAWV = 4'b1000
	} phase_t;

	state_t                        state_q;
	phase_t                        phase_q;
	logic [STEP_W-1:0]             step_q;

	logic [jpvf_pkg::GAIN_W-1:0]   pole_q;
	logic [jpvf_pkg::GAIN_W-1:0]   tap_q;

	logic [127:0]                  mem [JOINTS];
	logic [127:0]                  rdata_q;
	logic [JOINTS-1:0]             valid_q;

	logic [IDX_W-1:0]              jidx_q;
	logic [jpvf_pkg::JOINT_W-1:0]  joint_q;
	logic signed [31:0]            pos_q;
	logic [jpvf_pkg::PERIOD_W-1:0] period_q;

	logic signed [31:0]            fp_old_q;
	logic signed [31:0]            lrp_q;
	logic signed [31:0]            lrv_q;
	logic signed [31:0]            fv_old_q;
	logic signed [31:0]            fp_new_q;
	logic signed [31:0]            tmpv_q;
	logic signed [31:0]            fv_new_q;
	logic signed [31:0]            rawv_q;
	logic                          sat_q;

	logic [32:0]                   mag_q;
	logic                          neg_q;
	logic signed [63:0]            acc_q;
	logic signed [62:0]            prod_s1;
	logic                          prod_shift_s1;
	logic                          prod_vld_s1;
	logic [29:0]                   rem_q;
	logic [32:0]                   quot_q;
	logic                          ovf_q;

	jpvf_pkg::result_t             out_q;
	logic                          out_valid_q;

	logic                          accept;
	logic                          joint_ok;
	logic                          start;
	logic [JW_W-1:0]               jwide;
	logic [IDX_W-1:0]              rd_addr;
	logic                          hit;
	logic                          lowpass;
	logic                          mac_last;
	logic                          div_last;
	logic                          out_load;
	logic                          mem_we;

	logic [29:0]                   mul_a;
	logic signed [31:0]            mul_b;
	logic                          mul_go;
	logic                          mul_shift;
	logic signed [62:0]            prod_c;
	logic signed [63:0]            prod_ext;
	logic signed [63:0]            addend;

	logic signed [63:0]            lp_sh;
	logic                          lp_hi;
	logic                          lp_lo;
	logic signed [31:0]            lp_res;
	logic                          lp_clip;

	logic signed [32:0]            diff;
	logic [30:0]                   div_r2;
	logic                          div_ge;
	logic [30:0]                   div_sub;
	logic [31:0]                   rt_mag;
	logic                          rt_clip;
	logic signed [31:0]            rt_res;

	// handshake and decode
	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign joint_ok     = ({3'b000, sample.data.joint_index} < 7'(JOINTS));
	assign start        = accept && (sample.data.period_ns != '0) && joint_ok;
	assign jwide        = JW_W'(sample.data.joint_index);
	assign rd_addr      = jwide[IDX_W-1:0];
	assign hit          = valid_q[jidx_q];

	assign lowpass  = (phase_q == PH_POS) || (phase_q == PH_VEL);
	assign mac_last = lowpass ? (step_q == LP_LAST) : (step_q == RT_LAST);
	assign div_last = (step_q == DIV_LAST);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign mem_we   = out_load;

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// shared multiplier operand select
	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_go    = 1'b0;
		mul_shift = 1'b0;
		if (state_q == ST_MAC) begin
			if (lowpass) begin
				case (step_q)
					6'd0: begin
						mul_a  = 30'(pole_q);
						mul_b  = (phase_q == PH_POS) ? fp_old_q : fv_old_q;
						mul_go = 1'b1;
					end
					6'd1: begin
						mul_a  = 30'(tap_q);
						mul_b  = (phase_q == PH_POS) ? lrp_q : lrv_q;
						mul_go = 1'b1;
					end
					6'd2: begin
						mul_a  = 30'(tap_q);
						mul_b  = (phase_q == PH_POS) ? pos_q : tmpv_q;
						mul_go = 1'b1;
					end
					default: ;
				endcase
			end else begin
				case (step_q)
					6'd0: begin
						mul_a  = jpvf_pkg::NS_PER_S;
						mul_b  = $signed(32'(mag_q[15:0]));
						mul_go = 1'b1;
					end
					6'd1: begin
						mul_a     = jpvf_pkg::NS_PER_S;
						mul_b     = $signed(32'(mag_q[32:16]));
						mul_go    = 1'b1;
						mul_shift = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign prod_c   = $signed({1'b0, mul_a}) * mul_b;
	assign prod_ext = 64'(prod_s1);
	assign addend   = prod_shift_s1 ? (prod_ext <<< 16) : prod_ext;

	// q15 rounding and 32-bit clamp of the filter sum
	assign lp_sh   = acc_q >>> 15;
	assign lp_hi   = lp_sh > 64'(jpvf_pkg::Q_MAX);
	assign lp_lo   = lp_sh < 64'(jpvf_pkg::Q_MIN);
	assign lp_clip = lp_hi || lp_lo;
	assign lp_res  = lp_hi ? jpvf_pkg::Q_MAX : (lp_lo ? jpvf_pkg::Q_MIN : lp_sh[31:0]);

	assign diff = (phase_q == PH_TMPV) ? (33'(fp_new_q) - 33'(fp_old_q))
	                                   : (33'(pos_q) - 33'(lrp_q));

	// restoring divider, one quotient bit per cycle
	assign div_r2  = {rem_q, acc_q[32]};
	assign div_ge  = div_r2 >= {1'b0, period_q};
	assign div_sub = div_r2 - {1'b0, period_q};

	assign rt_mag  = quot_q[31:0];
	assign rt_clip = ovf_q || (neg_q ? (quot_q > RT_NEG_LIM) : (quot_q > RT_POS_LIM));
	assign rt_res  = rt_clip ? (neg_q ? jpvf_pkg::Q_MIN : jpvf_pkg::Q_MAX)
	                         : (neg_q ? $signed(~rt_mag + 32'd1) : $signed(rt_mag));

	// joint state memory
	always_ff @(posedge clk) begin
		if (start) begin
			rdata_q <= mem[rd_addr];
		end
		if (mem_we) begin
			mem[jidx_q] <= {pos_q, fp_new_q, rawv_q, fv_new_q};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_POS;
			step_q      <= STEP_ZERO;
			pole_q      <= jpvf_pkg::POLE_RST;
			tap_q       <= jpvf_pkg::TAP_RST;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= mul_go;
			if (cfg_we) begin
				case (cfg_index)
					jpvf_pkg::CFG_POLE: pole_q <= cfg_wdata;
					jpvf_pkg::CFG_TAP:  tap_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (mem_we) begin
				valid_q[jidx_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					phase_q <= PH_POS;
					step_q  <= STEP_ZERO;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (mac_last) begin
						step_q <= STEP_ZERO;
						if (lowpass) begin
							phase_q <= (phase_q == PH_POS) ? PH_TMPV : PH_RAWV;
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_DIV;
						end
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_PREP: begin
					step_q  <= STEP_ZERO;
					state_q <= ST_MAC;
				end
				ST_DIV: begin
					if (div_last) begin
						step_q <= STEP_ZERO;
						if (phase_q == PH_TMPV) begin
							phase_q <= PH_VEL;
							state_q <= ST_MAC;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						step_q <= step_q + 6'd1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1       <= prod_c;
		prod_shift_s1 <= mul_shift;
		if (start) begin
			jidx_q   <= rd_addr;
			joint_q  <= sample.data.joint_index;
			pos_q    <= sample.data.position_sample;
			period_q <= sample.data.period_ns;
			sat_q    <= 1'b0;
		end
		if (out_load) begin
			out_q.joint_out             <= joint_q;
			out_q.filtered_position_out <= fp_new_q;
			out_q.filtered_velocity_out <= fv_new_q;
			out_q.velocity_saturated    <= sat_q;
		end
		case (state_q)
			ST_LOAD: begin
				lrp_q    <= hit ? $signed(rdata_q[127:96]) : '0;
				fp_old_q <= hit ? $signed(rdata_q[95:64]) : '0;
				lrv_q    <= hit ? $signed(rdata_q[63:32]) : '0;
				fv_old_q <= hit ? $signed(rdata_q[31:0]) : '0;
				acc_q    <= RND_HALF;
			end
			ST_MAC: begin
				if (prod_vld_s1) begin
					acc_q <= acc_q + addend;
				end
				if (mac_last && lowpass) begin
					if (phase_q == PH_POS) begin
						fp_new_q <= lp_res;
					end else begin
						fv_new_q <= lp_res;
						sat_q    <= sat_q | lp_clip;
					end
				end
			end
			ST_PREP: begin
				neg_q <= diff[32];
				mag_q <= diff[32] ? $unsigned(-diff) : $unsigned(diff);
				acc_q <= {35'd0, period_q[29:1]};
			end
			ST_DIV: begin
				if (step_q == STEP_ZERO) begin
					rem_q  <= acc_q[62:33];
					ovf_q  <= acc_q[62:33] >= period_q;
					quot_q <= '0;
				end else if (!div_last) begin
					rem_q  <= div_ge ? div_sub[29:0] : div_r2[29:0];
					quot_q <= {quot_q[31:0], div_ge};
					acc_q  <= acc_q <<< 1;
				end else begin
					sat_q <= sat_q | rt_clip;
					if (phase_q == PH_TMPV) begin
						tmpv_q <= rt_res;
						acc_q  <= RND_HALF;
					end else begin
						rawv_q <= rt_res;
					end
				end
			end
			default: ;
		endcase
	end

	`JPVF_ASSERT_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result word without finished computation")
	`JPVF_ASSERT_NXT(a_drop_returns_idle, accept && !start, state_q == ST_IDLE, "dropped word did not leave the block idle")
	`JPVF_ASSERT_IMP(a_valid_grows, 1'b1, (valid_q & $past(valid_q)) == $past(valid_q), "joint valid bit cleared")
	`JPVF_ASSERT_IMP(a_rem_below_div, (state_q == ST_DIV) && (step_q != STEP_ZERO) && !ovf_q, rem_q < period_q, "divider remainder not below divisor")

endmodule

`default_nettype wire

### verif/jpvf_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpvf_filter_checker
// Watches the gain write port and both stream channels of the joint
// position/velocity filter. It keeps its own per-joint filter state and gains,
// predicts one result word per accepted sample with nonzero period and valid
// joint, and compares each accepted result word field by field with the
// oldest prediction. Reports the number of failures and of outstanding results.
// ----------------------------------------------------------------------------
module jpvf_filter_checker
	import jpvf_pkg::*;
#(
	parameter int unsigned JOINTS = JOINTS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [GAIN_W-1:0]    cfg_wdata,
	jpvf_sample_if              sample,
	jpvf_result_if              result,
	output int                  fail_count,
	output int                  pending
);

	int pole_q;
	int tap_q;
	logic signed [31:0] raw_pos [JOINTS];
	logic signed [31:0] flt_pos [JOINTS];
	logic signed [31:0] raw_vel [JOINTS];
	logic signed [31:0] flt_vel [JOINTS];
	result_t filter_results_q [$];

	function automatic logic signed [31:0] clip32(input longint v, inout logic clipped);
		if (v > longint'(Q_MAX)) begin
			clipped = 1'b1;
			return Q_MAX;
		end
		if (v < longint'(Q_MIN)) begin
			clipped = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction

	// q0.15 gains times q16.16 values, rounded half up back to q16.16
	function automatic logic signed [31:0] smooth(input logic signed [31:0] prev_out, prev_in,
			new_in, inout logic clipped);
		longint acc;
		acc = longint'(pole_q) * longint'(prev_out) + longint'(tap_q) * longint'(prev_in)
			+ longint'(tap_q) * longint'(new_in);
		return clip32((acc + 64'sd16384) >>> 15, clipped);
	endfunction

	// delta per ns scaled to per second, rounded half away from zero
	function automatic logic signed [31:0] ns_rate(input longint delta,
			input longint unsigned period, inout logic clipped);
		longint unsigned mag;
		longint unsigned q;
		mag = (delta < 0) ? -delta : delta;
		q = (mag * 64'd1000000000 + (period >> 1)) / period;
		return clip32((delta < 0) ? -longint'(q) : longint'(q), clipped);
	endfunction

	function automatic void check_field(input string field, input longint want, got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : filter_watch
		logic spare;
		logic clipped;
		logic [JOINT_W-1:0] j;
		logic signed [31:0] fp_next;
		logic signed [31:0] tmp_vel;
		logic signed [31:0] fv_next;
		logic signed [31:0] rv_next;
		result_t want;
		result_t got;
		if (!arst_n) begin
			pole_q = int'(POLE_RST);
			tap_q = int'(TAP_RST);
			for (int k = 0; k < JOINTS; k++) begin
				raw_pos[k] = '0;
				flt_pos[k] = '0;
				raw_vel[k] = '0;
				flt_vel[k] = '0;
			end
			filter_results_q.delete();
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = result.data;
				if (filter_results_q.size() == 0) begin
					$error("result word for joint %0d with nothing expected", got.joint_out);
					fail_count++;
				end else begin
					want = filter_results_q.pop_front();
					check_field("joint_out", want.joint_out, got.joint_out);
					check_field("filtered_position_out", $signed(want.filtered_position_out),
						$signed(got.filtered_position_out));
					check_field("filtered_velocity_out", $signed(want.filtered_velocity_out),
						$signed(got.filtered_velocity_out));
					check_field("velocity_saturated", want.velocity_saturated,
						got.velocity_saturated);
				end
			end
			if (sample.valid && sample.ready) begin
				j = sample.data.joint_index;
				if (sample.data.period_ns != '0 && j < JOINTS) begin
					spare = 1'b0;
					clipped = 1'b0;
					fp_next = smooth(flt_pos[j], raw_pos[j], sample.data.position_sample, spare);
					tmp_vel = ns_rate(longint'(fp_next) - longint'(flt_pos[j]),
						sample.data.period_ns, clipped);
					fv_next = smooth(flt_vel[j], raw_vel[j], tmp_vel, clipped);
					rv_next = ns_rate(longint'(sample.data.position_sample) - longint'(raw_pos[j]),
						sample.data.period_ns, clipped);
					flt_pos[j] = fp_next;
					flt_vel[j] = fv_next;
					raw_vel[j] = rv_next;
					raw_pos[j] = sample.data.position_sample;
					want.joint_out = j;
					want.filtered_position_out = fp_next;
					want.filtered_velocity_out = fv_next;
					want.velocity_saturated = clipped;
					filter_results_q.push_back(want);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLE: pole_q = int'(cfg_wdata);
					CFG_TAP: tap_q = int'(cfg_wdata);
					default: ;
				endcase
			end
			pending = filter_results_q.size();
		end
	end

endmodule

### verif/joint_position_velocity_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_position_velocity_filter_test
// Drives the joint position/velocity filter with a directed set of edge
// samples and then random per-joint position streams under several gain
// settings, with random stalls on both channels and one long result
// back-pressure stretch. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module joint_position_velocity_filter_test;
	import jpvf_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_CYCLES   = 800;
	localparam int TIMEOUT_NS    = 2_000_000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_wdata;
	int fail_count;
	int pending;
	int tx_idle_pct = 31;
	int rx_idle_pct = 76;
	logic rx_hold = 1'b0;
	logic squeeze_start = 1'b0;
	logic [31:0] last_pos [JOINTS_DEF];

	jpvf_sample_if sample_ch ();
	jpvf_result_if result_ch ();

	joint_position_velocity_filter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	jpvf_filter_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch),
		.result    (result_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic offer_sample(input logic [JOINT_W-1:0] joint, input logic [31:0] pos,
			input logic [PERIOD_W-1:0] per);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data.joint_index <= joint;
		sample_ch.data.position_sample <= pos;
		sample_ch.data.period_ns <= per;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	always begin
		@(negedge clk);
		result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long result stall so the output register fills and the input backs up
	initial begin
		wait (squeeze_start);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int n;
		int count;
		int r;
		logic [JOINT_W-1:0] jj;
		logic [31:0] pos;
		logic [PERIOD_W-1:0] per;
		logic [31:0] d;
		logic [GAIN_W-1:0] pole;
		logic [GAIN_W-1:0] tap;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_POLE;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		for (int k = 0; k < JOINTS_DEF; k++) last_pos[k] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed edge samples under reset gains
		offer_sample(4'd0, 32'h0001_0000, 30'd1_000_000);
		offer_sample(4'd0, 32'h0001_0100, 30'd1_000_000);
		offer_sample(4'd0, 32'h0001_0100, 30'd0);
		offer_sample(4'd0, 32'h0001_0200, 30'd1_000_000);
		offer_sample(4'd1, 32'h7fff_ffff, 30'd1);
		offer_sample(4'd1, 32'h8000_0000, 30'd1);
		offer_sample(4'd1, 32'h8000_0000, 30'h3fff_ffff);
		offer_sample(4'd2, 32'h8000_0000, 30'h3fff_ffff);
		offer_sample(4'd2, 32'h7fff_ffff, 30'h3fff_ffff);
		offer_sample(4'd15, 32'hffff_ffff, 30'd2);
		offer_sample(4'd15, 32'h0000_0000, 30'd3);
		offer_sample(4'd15, 32'h0000_0001, 30'd2);
		offer_sample(4'd14, 32'h1234_5678, 30'd0);
		offer_sample(4'd14, 32'hedcb_a988, 30'd999_999_999);
		offer_sample(4'd7, 32'h0000_8000, 30'd1_000_000);
		offer_sample(4'd7, 32'hffff_8000, 30'd1_000_000);
		offer_sample(4'd3, 32'h7fff_ffff, 30'd1_000_000);
		offer_sample(4'd3, 32'h7fff_ffff, 30'd1_000_000);

		for (int phase = 1; phase <= 4; phase++) begin
			sample_ch.valid <= 1'b0;
			while (pending != 0) @(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			case (phase)
				1: begin
					pole = '1;
					tap = '1;
					count = 200;
				end
				2: begin
					pole = '0;
					tap = '0;
					count = 150;
					tx_idle_pct = 76;
					rx_idle_pct = 31;
				end
				3: begin
					pole = GAIN_W'($urandom_range(32767));
					tap = GAIN_W'($urandom_range(32767));
					count = 200;
				end
				default: begin
					pole = POLE_RST;
					tap = TAP_RST;
					count = 230;
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			write_gain(CFG_POLE, pole);
			write_gain(CFG_TAP, tap);
			if (phase == 1) begin
				// filtered position overflow with full gains
				for (int k = 0; k < 3; k++) begin
					offer_sample(4'd9, 32'h7fff_ffff, 30'd1_000_000);
					offer_sample(4'd10, 32'h8000_0000, 30'd1_000_000);
				end
			end
			if (phase == 4) squeeze_start = 1'b1;
			n = 0;
			while (n < count) begin
				jj = JOINT_W'($urandom_range(JOINTS_DEF - 1));
				r = $urandom_range(99);
				if (r < 5) per = '0;
				else if (r < 10) per = PERIOD_W'($urandom());
				else if (r < 25) per = PERIOD_W'($urandom_range(1, 2000));
				else per = PERIOD_W'($urandom_range(500_000, 2_000_000));
				r = $urandom_range(99);
				if (r < 10) begin
					pos = $urandom();
				end else if (r < 15) begin
					pos = r[0] ? 32'h7fff_ffff : 32'h8000_0000;
				end else begin
					d = 32'd1 << $urandom_range(4, 20);
					pos = last_pos[jj] + $urandom_range(2 * d) - d;
				end
				offer_sample(jj, pos, per);
				if (per != '0) begin
					last_pos[jj] = pos;
					n++;
				end
			end
		end

		sample_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### joint_position_velocity_filter.f
+incdir+hw/rtl
hw/rtl/jpvf_pkg.sv
hw/rtl/jpvf_if.sv
hw/rtl/joint_position_velocity_filter.sv
verif/jpvf_filter_checker.sv
verif/joint_position_velocity_filter_test.sv
